// ----- src/bhm_pkg.sv -----
// Package for the bucketed hash multimap: command codes, states and shared widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bhm_pkg;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned TOTAL_W = 14;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [CNT_W-1:0] RESULT_MAX = 5'd16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILL,
        ST_ISSUE,
        ST_CHECK,
        ST_EMIT,
        ST_DONE,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- src/bhm_if.sv -----
// Valid/ready channel interfaces for commands and results.
// Depends on bhm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bhm_cmd_if import bhm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  result_limit;
    modport source (output valid, command, key, value, result_limit, input ready);
    modport sink   (input valid, command, key, value, result_limit, output ready);
endinterface

interface bhm_res_if import bhm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [VAL_W-1:0]  found_value;
    logic [CNT_W-1:0]  match_count;
    logic              last;
    modport source (output valid, status, found_value, match_count, last, input ready);
    modport sink   (input valid, status, found_value, match_count, last, output ready);
endinterface
`default_nettype wire

// ----- src/bhm_mod.sv -----
// Key modulo the bucket count by folding: 2^B_W is congruent to a small constant,
// so the upper bits fold into the lower ones, then one compare and subtract.
// Depends on bhm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bhm_mod import bhm_pkg::*; #(
    parameter int unsigned NUM_BUCKETS = 1021,
    parameter int unsigned B_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_done,
    output logic [B_W-1:0]        o_bucket
);
    localparam logic [KEY_W-1:0] NB  = KEY_W'(NUM_BUCKETS);
    // 2^B_W mod NUM_BUCKETS; each fold drops the value by a multiple of the count
    localparam logic [KEY_W-1:0] RED = KEY_W'((2**B_W) % NUM_BUCKETS);

    logic [KEY_W-1:0]     r_x;
    logic                 r_busy;
    logic [KEY_W-B_W-1:0] w_hi;
    logic [KEY_W-1:0]     w_fold;

    assign w_hi     = r_x[KEY_W-1:B_W];
    assign w_fold   = KEY_W'(w_hi) * RED + KEY_W'(r_x[B_W-1:0]);
    assign o_bucket = r_x[B_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (w_hi == '0) && (r_x < NB);
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_key;
            end else if (r_busy) begin
                if (w_hi != '0)    r_x <= w_fold;
                else if (r_x >= NB) r_x <= r_x - NB;
                else               r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/bucketed_hash_multimap_unit.sv -----
// Bucketed hash multimap: command and result channels, bucket fill and slot memories.
// Depends on bhm_pkg, bhm_if, bhm_mod.
//
// Use: send one command beat (insert, lookup, update, remove) on i_cmd; results
// come out on o_res, the final one flagged by last. Lookup gives one beat per
// match up to its limit (capped at 16), or one empty beat; others give one beat.
// One command is in flight at a time; i_cmd.ready is high only while idle.
// Steps: the bucket index (folding 2^10 = 3 mod 1021, then a final subtract),
// the fill read, then an issue and a check per slot walked plus an emit per
// lookup match, and a close (end test, fill write-back, result load). Insert
// walks none, update and remove walk the whole filled part. The next command
// is taken from the cycle after the final beat is loaded.
// Each match beat is held back until the next match is known, to flag the last.
// Reset: fill memory is cleared one entry a cycle over all NUM_BUCKETS entries;
// no command is taken until it ends. Slot memories are not cleared.
// A stalled receiver holds the result beat; the walk waits at the next beat.
`timescale 1ns / 1ps
`default_nettype none
module bucketed_hash_multimap_unit import bhm_pkg::*; #(
    parameter int unsigned NUM_BUCKETS = 1021,
    parameter int unsigned SLOTS_PER_BUCKET = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bhm_cmd_if.sink   i_cmd,
    bhm_res_if.source o_res
);
    localparam int unsigned B_W = $clog2(NUM_BUCKETS);
    localparam int unsigned F_W = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int unsigned A_W = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET);
    localparam int unsigned DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam logic [F_W-1:0] SLOTS = F_W'(SLOTS_PER_BUCKET);

    logic [F_W-1:0]   fill_mem [NUM_BUCKETS];
    logic [KEY_W-1:0] key_mem  [DEPTH];
    logic [VAL_W-1:0] val_mem  [DEPTH];

    t_state           r_state, n_state;
    logic             r_clr;
    logic [B_W-1:0]   r_clr_idx;
    t_cmd             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_limit;
    logic [B_W-1:0]   r_b;
    logic [F_W-1:0]   r_fill, r_rd, r_wr;
    logic [CNT_W-1:0] r_n;
    logic [F_W-1:0]   r_fill_q;
    logic [KEY_W-1:0] r_kq;
    logic [VAL_W-1:0] r_vq;
    logic [VAL_W-1:0] r_hv;
    logic [VAL_W-1:0] r_pv;
    logic             r_ov;
    logic             r_os;
    logic [VAL_W-1:0] r_ofv;
    logic [CNT_W-1:0] r_oc;
    logic             r_ol;

    logic             w_mod_start, w_mod_done;
    logic [B_W-1:0]   w_b;
    logic [A_W-1:0]   w_base, w_rd_addr, w_wr_addr;
    logic             w_hit;
    logic             w_walk_end;
    logic             w_load;

    bhm_mod #(.NUM_BUCKETS(NUM_BUCKETS), .B_W(B_W)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start), .i_key(i_cmd.key),
        .o_done(w_mod_done), .o_bucket(w_b)
    );

    assign i_cmd.ready = (r_state == ST_IDLE) && !r_clr;
    assign w_mod_start = i_cmd.valid && i_cmd.ready;
    assign w_base      = A_W'(r_b) * A_W'(SLOTS_PER_BUCKET);
    assign w_rd_addr   = w_base + A_W'(r_rd);
    assign w_wr_addr   = w_base + A_W'(r_wr);
    assign w_hit       = (r_kq == r_key);
    assign w_walk_end  = (r_rd >= r_fill) || (r_cmd == CMD_LOOKUP && r_n >= r_limit);
    // a beat is loaded at the close, or at a match once an earlier one is pending
    assign w_load      = ((r_state == ST_EMIT && r_n != CNT_W'(1)) || r_state == ST_OUT)
                         && (!r_ov || o_res.ready);

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_os;
    assign o_res.found_value = r_ofv;
    assign o_res.match_count = r_oc;
    assign o_res.last        = r_ol;

    // fill memory: clearing pass, read and write
    always_ff @(posedge i_clk) begin
        if (r_clr) fill_mem[r_clr_idx] <= '0;
        else if (r_state == ST_DONE && (r_cmd == CMD_INSERT || r_cmd == CMD_REMOVE))
            fill_mem[r_b] <= r_wr;
        r_fill_q <= fill_mem[w_b];
    end

    // slot memories: one read, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ISSUE && r_cmd == CMD_INSERT && r_fill < SLOTS) begin
            key_mem[w_wr_addr] <= r_key;
            val_mem[w_wr_addr] <= r_val;
        end else if (r_state == ST_CHECK && r_cmd == CMD_UPDATE && w_hit) begin
            val_mem[w_wr_addr] <= r_val;
        end else if (r_state == ST_CHECK && r_cmd == CMD_REMOVE && !w_hit) begin
            key_mem[w_wr_addr] <= r_kq;
            val_mem[w_wr_addr] <= r_vq;
        end
        r_kq <= key_mem[w_rd_addr];
        r_vq <= val_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_mod_start) n_state = ST_DIV;
            ST_DIV:   if (w_mod_done) n_state = ST_FILL;
            ST_FILL:  n_state = ST_ISSUE;
            ST_ISSUE: begin
                if (r_cmd == CMD_INSERT || w_walk_end) n_state = ST_DONE;
                else n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_cmd == CMD_LOOKUP && w_hit) n_state = ST_EMIT;
                else n_state = ST_ISSUE;
            end
            ST_EMIT:  if (r_n == CNT_W'(1) || !r_ov || o_res.ready) n_state = ST_ISSUE;
            ST_DONE:  n_state = ST_OUT;
            ST_OUT:   if (!r_ov || o_res.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + B_W'(1);
                if (r_clr_idx == B_W'(NUM_BUCKETS - 1)) r_clr <= 1'b0;
            end
            if (w_load)           r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_mod_start) begin
                    r_cmd   <= t_cmd'(i_cmd.command);
                    r_key   <= i_cmd.key;
                    r_val   <= i_cmd.value;
                    r_limit <= (i_cmd.result_limit > RESULT_MAX) ? RESULT_MAX
                                                                  : i_cmd.result_limit;
                end
                ST_DIV: r_b <= w_b;
                ST_FILL: begin
                    r_fill <= (r_fill_q > SLOTS) ? SLOTS : r_fill_q;
                    r_rd   <= '0;
                    r_wr   <= (r_cmd == CMD_INSERT) ?
                              ((r_fill_q > SLOTS) ? SLOTS : r_fill_q) : '0;
                    r_n    <= '0;
                end
                ST_ISSUE: if (r_cmd == CMD_INSERT) begin
                    // slot written this cycle unless the bucket is full
                    if (r_fill < SLOTS) r_wr <= r_wr + F_W'(1);
                end else if (!w_walk_end) begin
                    r_rd <= r_rd + F_W'(1);
                end
                ST_CHECK: begin
                    if (w_hit) begin
                        if (r_n != COUNT_MAX) r_n <= r_n + CNT_W'(1);
                        r_hv <= r_vq;
                    end
                    // update: r_wr follows the slot checked; remove: next kept slot
                    if (r_cmd == CMD_UPDATE || (r_cmd == CMD_REMOVE && !w_hit))
                        r_wr <= r_wr + F_W'(1);
                end
                ST_EMIT: if (r_n == CNT_W'(1)) begin
                    r_pv <= r_hv;
                end else if (!r_ov || o_res.ready) begin
                    r_os  <= 1'b0;
                    r_ofv <= r_pv;
                    r_oc  <= r_n - CNT_W'(1);
                    r_ol  <= 1'b0;
                    r_pv  <= r_hv;
                end
                ST_OUT: if (!r_ov || o_res.ready) begin
                    r_os  <= (r_cmd == CMD_INSERT) && (r_fill >= SLOTS);
                    r_ofv <= (r_cmd == CMD_LOOKUP && r_n != '0) ? r_pv : '0;
                    r_oc  <= (r_cmd == CMD_INSERT) ? CNT_W'(r_wr) : r_n;
                    r_ol  <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sim/tb_bucketed_hash_multimap_unit.sv -----
// Self-checking testbench for bucketed_hash_multimap_unit: directed table, then random traffic.
// Predicts results with a behavioural multimap; depends on bhm_pkg, bhm_if and the RTL.
`timescale 1ns / 1ps
module tb_bucketed_hash_multimap_unit;
    import bhm_pkg::*;

    localparam int NB = 1021;
    localparam int SPB = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] found_value;
        logic [CNT_W-1:0] match_count;
        logic             last;
    } t_beat;

    typedef struct {
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] lim;
        bit               has_exp;
        t_beat            exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bhm_cmd_if cmd_ch ();
    bhm_res_if res_ch ();

    bucketed_hash_multimap_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    // model of the table
    logic [CNT_W-1:0] mdl_fill [NB];
    logic [KEY_W-1:0] mdl_key  [NB*SPB];
    logic [VAL_W-1:0] mdl_val  [NB*SPB];
    t_beat beats_due [$];
    t_beat typed_due [$];   // typed-in expectation per directed row, used on its last beat
    int fail_cnt = 0;
    int cycle_cnt = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_beat mk(logic s, logic [VAL_W-1:0] v, int c, logic l);
        t_beat b;
        b.status = s;
        b.found_value = v;
        b.match_count = (c > 31) ? 5'd31 : c[CNT_W-1:0];
        b.last = l;
        return b;
    endfunction

    task automatic predict_op(t_cmd cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                              logic [CNT_W-1:0] lim);
        int b, base, fill, n, w, l;
        b = key % NB;
        base = b * SPB;
        fill = mdl_fill[b];
        n = 0;
        case (cmd)
            CMD_INSERT: begin
                if (fill >= SPB) begin
                    beats_due.push_back(mk(1'b1, '0, fill, 1'b1));
                end else begin
                    mdl_key[base+fill] = key;
                    mdl_val[base+fill] = val;
                    mdl_fill[b] = fill + 1;
                    beats_due.push_back(mk(1'b0, '0, fill + 1, 1'b1));
                end
            end
            CMD_LOOKUP: begin
                l = (lim > RESULT_MAX) ? SPB : lim;
                for (int i = 0; i < fill && n < l; i++) begin
                    if (mdl_key[base+i] == key) begin
                        n++;
                        beats_due.push_back(mk(1'b0, mdl_val[base+i], n, 1'b0));
                    end
                end
                if (n == 0) beats_due.push_back(mk(1'b0, '0, 0, 1'b1));
                else beats_due[$].last = 1'b1;
            end
            CMD_UPDATE: begin
                for (int i = 0; i < fill; i++) begin
                    if (mdl_key[base+i] == key) begin
                        mdl_val[base+i] = val;
                        n++;
                    end
                end
                beats_due.push_back(mk(1'b0, '0, n, 1'b1));
            end
            default: begin
                w = 0;
                for (int i = 0; i < fill; i++) begin
                    if (mdl_key[base+i] == key) begin
                        n++;
                    end else begin
                        mdl_key[base+w] = mdl_key[base+i];
                        mdl_val[base+w] = mdl_val[base+i];
                        w++;
                    end
                end
                mdl_fill[b] = w;
                beats_due.push_back(mk(1'b0, '0, n, 1'b1));
            end
        endcase
    endtask

    // sender: valid stays up between back-to-back beats
    task automatic send(t_cmd cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                        logic [CNT_W-1:0] lim, int gap);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.key <= key;
        cmd_ch.value <= val;
        cmd_ch.result_limit <= lim;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_op(cmd, key, val, lim);
    endtask

    // keys in a few buckets so buckets fill up and matches repeat
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 5) * NB + $urandom_range(0, 2);
        if (r < 9) return 32'hFFFF_FFFF - $urandom_range(0, 3) * NB;
        return $urandom;
    endfunction

    t_row rows [$];

    initial begin
        t_row r;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_INSERT;
        cmd_ch.key = '0;
        cmd_ch.value = '0;
        cmd_ch.result_limit = '0;
        for (int i = 0; i < NB; i++) mdl_fill[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: {cmd, key, value, limit, typed?, expected}
        rows.push_back('{CMD_LOOKUP, 32'd5, 32'd0, 5'd16, 1, mk(0, 0, 0, 1)});
        rows.push_back('{CMD_UPDATE, 32'd5, 32'd1, 5'd0, 1, mk(0, 0, 0, 1)});
        rows.push_back('{CMD_REMOVE, 32'd5, 32'd0, 5'd0, 1, mk(0, 0, 0, 1)});
        rows.push_back('{CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 5'd0, 1, mk(0, 0, 1, 1)});
        rows.push_back('{CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 5'd0, 1, mk(0, 0, 1, 1)});
        rows.push_back('{CMD_LOOKUP, 32'd0, 32'd0, 5'd0, 1, mk(0, 0, 0, 1)});
        rows.push_back('{CMD_LOOKUP, 32'd0, 32'd0, 5'd31, 0, mk(0, 0, 0, 0)});
        // fill bucket 7 to the brim, alternating two keys
        for (int i = 0; i < 16; i++)
            rows.push_back('{CMD_INSERT, (i % 2) ? 32'd7 + NB : 32'd7, i, 5'd0, 1,
                             mk(0, 0, i + 1, 1)});
        rows.push_back('{CMD_INSERT, 32'd7, 32'hA5A5_5A5A, 5'd0, 1, mk(1, 0, 16, 1)});
        rows.push_back('{CMD_LOOKUP, 32'd7, 32'd0, 5'd3, 0, mk(0, 0, 0, 0)});
        rows.push_back('{CMD_UPDATE, 32'd7 + NB, 32'h1234_5678, 5'd0, 1, mk(0, 0, 8, 1)});
        rows.push_back('{CMD_REMOVE, 32'd7, 32'd0, 5'd0, 1, mk(0, 0, 8, 1)});
        rows.push_back('{CMD_LOOKUP, 32'd7 + NB, 32'd0, 5'd20, 0, mk(0, 0, 0, 0)});

        foreach (rows[i]) begin
            if (rows[i].has_exp) typed_due.push_back(rows[i].exp);
            else typed_due.push_back('1);
            send(rows[i].cmd, rows[i].key, rows[i].val, rows[i].lim, $urandom_range(0, 11));
        end

        for (int i = 0; i < 480; i++) begin
            t_cmd c;
            c = t_cmd'($urandom_range(0, 3));
            if (i == 200) hold_off = 1'b1;
            send(c, pick_key(), $urandom, 5'($urandom_range(0, 31)),
                 (i % 60 < 15) ? 0 : $urandom_range(0, 11));
        end
        cmd_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver
    initial begin
        t_beat got, want, typed;
        int wait_n;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            got = {res_ch.status, res_ch.found_value, res_ch.match_count, res_ch.last};
            if (beats_due.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                want = beats_due.pop_front();
                // typed expectations from the table stand for their one-beat rows
                if (typed_due.size() != 0 && want.last) begin
                    typed = typed_due.pop_front();
                    if (typed != '1) want = typed;
                end
                if (got.status != want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); fail_cnt++;
                end
                if (got.found_value != want.found_value) begin
                    $error("found_value exp %h got %h", want.found_value, got.found_value);
                    fail_cnt++;
                end
                if (got.match_count != want.match_count) begin
                    $error("match_count exp %0d got %0d", want.match_count, got.match_count);
                    fail_cnt++;
                end
                if (got.last != want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); fail_cnt++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- bucketed_hash_multimap_unit.f -----
src/bhm_pkg.sv
src/bhm_if.sv
src/bhm_mod.sv
src/bucketed_hash_multimap_unit.sv
sim/tb_bucketed_hash_multimap_unit.sv
